// ===== hdl/latency_aware_dispatch_arbiter_macros.svh =====
// ----------------------------------------------------------------------------
// Dispatch arbiter assertion macros
// Assertion helpers used by the dispatch arbiter top module.
// ----------------------------------------------------------------------------
`ifndef LATENCY_AWARE_DISPATCH_ARBITER_MACROS_SVH
`define LATENCY_AWARE_DISPATCH_ARBITER_MACROS_SVH

`ifndef ASSERT_OFF
`define LADARB_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("dispatch arbiter: same-cycle check failed");
`define LADARB_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("dispatch arbiter: next-cycle check failed");
`else
`define LADARB_ASSERT_IMP(lbl, a, b)
`define LADARB_ASSERT_NXT(lbl, a, b)
`endif

`endif

// ===== hdl/ladarb_pkg.sv =====
// ----------------------------------------------------------------------------
// Dispatch arbiter package
// Shared widths, register indexes, strategy and kind codes, and cell types.
// ----------------------------------------------------------------------------
package ladarb_pkg;

  localparam int DEF_NUM_SLOTS    = 8;
  localparam int DEF_WINDOW_DEPTH = 16;

  localparam int LAT_W      = 24;
  localparam int SLOT_IDX_W = 4;
  localparam int HEAD_W     = 6;
  localparam int FILL_W     = 7;
  localparam int SUM_W      = LAT_W + HEAD_W;
  localparam int CNT_W      = 32;

  localparam logic [2:0] REG_STRATEGY   = 3'd0;
  localparam logic [2:0] REG_SLOT_COUNT = 3'd1;
  localparam logic [2:0] REG_SLOT_KINDS = 3'd2;
  localparam logic [2:0] REG_PRESENT    = 3'd3;
  localparam logic [2:0] REG_ALIVE      = 3'd4;

  localparam logic [2:0] STRAT_FASTEST      = 3'd0;
  localparam logic [2:0] STRAT_GPU_BACKFILL = 3'd1;
  localparam logic [2:0] STRAT_NPU_BACKFILL = 3'd2;
  localparam logic [2:0] STRAT_GPU_ONLY     = 3'd3;
  localparam logic [2:0] STRAT_NPU_ONLY     = 3'd4;

  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_GPU   = 2'd1;
  localparam logic [1:0] KIND_NPU   = 2'd2;

  localparam logic [2:0] PHASE_LAST = 3'd4;
  localparam logic [2:0] PREF_PICKS = 3'd4;

  typedef struct packed {
    logic                  fast_found;
    logic [SLOT_IDX_W-1:0] fast_idx;
    logic [LAT_W-1:0]      fast_avg;
    logic                  ap_found;
    logic [SLOT_IDX_W-1:0] ap_idx;
    logic                  kind_found;
    logic [SLOT_IDX_W-1:0] kind_idx;
  } scan_t;

  typedef struct packed {
    logic [HEAD_W-1:0] head;
    logic [FILL_W-1:0] fill;
    logic [SUM_W-1:0]  sum;
    logic [LAT_W-1:0]  avg;
    logic [CNT_W-1:0]  total;
    logic [CNT_W-1:0]  failed;
  } cell_stat_t;

  typedef struct packed {
    logic                  we;
    logic [SLOT_IDX_W-1:0] slot;
    cell_stat_t            stat;
  } cell_upd_t;

endpackage

// ===== hdl/ladarb_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ladarb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/ladarb_div.sv =====
// ----------------------------------------------------------------------------
// Window average divider
// Restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ladarb_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [ladarb_pkg::SUM_W-1:0]  dividend,
  input  logic [ladarb_pkg::FILL_W-1:0] divisor,
  output logic                       done,
  output logic [ladarb_pkg::LAT_W-1:0]  quotient
);
  import ladarb_pkg::*;

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [SUM_W-1:0]  dvd;
  logic [FILL_W-1:0] rem;
  logic [FILL_W-1:0] dvs;
  logic [FILL_W:0]   trial;
  logic              fits;

  assign trial    = {rem, dvd[SUM_W-1]};
  assign fits     = trial >= {1'b0, dvs};
  assign quotient = dvd[LAT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        dvd  <= dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        rem  <= fits ? FILL_W'(trial - {1'b0, dvs}) : trial[FILL_W-1:0];
        dvd  <= {dvd[SUM_W-2:0], fits};
        step <= step + STEP_W'(1);
        if (step == STEP_W'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/ladarb_cell.sv =====
// ----------------------------------------------------------------------------
// Slot cell
// Holds one slot's statistics and passes the selection scan to its neighbor.
// ----------------------------------------------------------------------------
module ladarb_cell #(
  parameter int IDX = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_use,
  input  logic                   alive,
  input  logic                   present,
  input  logic [1:0]             kind,
  input  logic [1:0]             want_kind,
  input  ladarb_pkg::scan_t      scan_in,
  output ladarb_pkg::scan_t      scan_out,
  input  ladarb_pkg::cell_upd_t  upd,
  output ladarb_pkg::cell_stat_t stat
);
  import ladarb_pkg::*;

  localparam logic [SLOT_IDX_W-1:0] MY_IDX = SLOT_IDX_W'(IDX);

  scan_t scan_next;
  logic  live;

  assign live = in_use && alive && present;

  always_comb begin
    scan_next = scan_in;
    if (live && stat.fill != '0 && (!scan_in.fast_found || stat.avg < scan_in.fast_avg)) begin
      scan_next.fast_found = 1'b1;
      scan_next.fast_idx   = MY_IDX;
      scan_next.fast_avg   = stat.avg;
    end
    if (live && !scan_in.ap_found) begin
      scan_next.ap_found = 1'b1;
      scan_next.ap_idx   = MY_IDX;
    end
    if (in_use && kind == want_kind && !scan_in.kind_found) begin
      scan_next.kind_found = 1'b1;
      scan_next.kind_idx   = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_out <= '0;
      stat     <= '0;
    end else begin
      scan_out <= scan_next;
      if (upd.we && upd.slot == MY_IDX) begin
        stat <= upd.stat;
      end
    end
  end

endmodule

// ===== hdl/latency_aware_dispatch_arbiter.sv =====
// ----------------------------------------------------------------------------
// Latency-aware dispatch arbiter
// Picks an execution slot per dispatch word and keeps per-slot latency stats.
// ----------------------------------------------------------------------------
// Input words arrive on in_valid/in_ready: op 0 asks for a slot, op 1 reports
// a completion on slot with latency_us and success. Every input word yields
// exactly one output word on out_valid/out_ready. Registers are written on the
// cfg channel, which is always ready; the user must write them only while no
// word is in flight, as the block itself does not enforce this.
// A dispatch with two or more slots in use steps the selection scan through
// the chain of slot cells before the result is set. A dispatch with fewer
// slots, a failed completion and a completion to a slot beyond NUM_SLOTS go
// straight to the output state. A successful completion reads the window
// memory, then forms the window average with the one-bit-per-cycle divider.
// One word is worked on at a time; in_ready rises again once the result sits
// in the output register, so a new word is taken while the receiver holds
// out_ready low. A stalled result stays on the outputs.
// Reset clears all counters, averages, the backfill phase and the registers,
// except alive_mask, which resets to all ones. The window memory needs no
// clearing since a read entry is used only after it was written.
// ----------------------------------------------------------------------------
`include "latency_aware_dispatch_arbiter_macros.svh"

module latency_aware_dispatch_arbiter #(
  parameter int NUM_SLOTS    = ladarb_pkg::DEF_NUM_SLOTS,
  parameter int WINDOW_DEPTH = ladarb_pkg::DEF_WINDOW_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [2:0]  slot,
  input  logic [23:0] latency_us,
  input  logic        success,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        dispatched,
  output logic [2:0]  chosen_slot,
  output logic [23:0] average_us,
  output logic [31:0] total_count,
  output logic [31:0] failed_count
);
  import ladarb_pkg::*;

  localparam int SLOT_W  = $clog2(NUM_SLOTS);
  localparam int WIN_AW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int RAM_AW  = SLOT_W + WIN_AW;
  localparam int SCAN_W  = $clog2(NUM_SLOTS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_SUM  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]  state;
  logic [SCAN_W-1:0] scan_cnt;
  logic [2:0]  phase;
  logic [1:0]  want_kind;
  logic [2:0]  strategy;
  logic [3:0]  slot_count;
  logic [15:0] slot_kinds;
  logic [7:0]  present_mask;
  logic [7:0]  alive_mask;

  logic [SLOT_IDX_W-1:0] slot_q;
  logic [LAT_W-1:0]      lat_q;
  cell_stat_t            work;

  logic             res_dispatched;
  logic [2:0]       res_slot;
  logic [LAT_W-1:0] res_avg;
  logic [CNT_W-1:0] res_total;
  logic [CNT_W-1:0] res_failed;

  logic [4:0]            n_used;
  logic [SLOT_IDX_W-1:0] in_slot;
  logic                  in_slot_ok;
  cell_stat_t            in_stat;
  scan_t                 scan_chain [NUM_SLOTS+1];
  cell_stat_t            stats [NUM_SLOTS];
  cell_upd_t             upd;
  logic                  upd_we;
  logic [SLOT_IDX_W-1:0] upd_slot;
  cell_stat_t            upd_stat;
  logic [SLOT_IDX_W-1:0] pick;

  cell_stat_t            ok_stat;
  cell_stat_t            fail_stat;
  cell_stat_t            sum_stat;
  cell_stat_t            done_stat;

  logic              ram_we;
  logic              ram_re;
  logic [RAM_AW-1:0] ram_addr;
  logic [LAT_W-1:0]  ram_rdata;

  logic              div_start;
  logic              div_done;
  logic [LAT_W-1:0]  div_q;
  logic              win_full;
  logic [SUM_W-1:0]  sum_new;
  logic [FILL_W-1:0] fill_new;
  logic [HEAD_W:0]   head_inc;

  assign cfg_ready  = 1'b1;
  assign in_ready   = state == S_IDLE;
  assign n_used     = ({1'b0, slot_count} > 5'(NUM_SLOTS)) ? 5'(NUM_SLOTS) : {1'b0, slot_count};
  assign in_slot    = SLOT_IDX_W'(slot);
  assign in_slot_ok = {2'b0, slot} < 5'(NUM_SLOTS);
  assign in_stat    = stats[in_slot[SLOT_W-1:0]];
  assign scan_chain[0] = '0;
  assign upd        = {upd_we, upd_slot, upd_stat};

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    logic       c_alive;
    logic       c_present;
    logic [1:0] c_kind;
    if (i < 8) begin : g_low
      assign c_alive   = alive_mask[i];
      assign c_present = present_mask[i];
      assign c_kind    = slot_kinds[2*i +: 2];
    end else begin : g_high
      assign c_alive   = 1'b0;
      assign c_present = 1'b0;
      assign c_kind    = KIND_OTHER;
    end
    ladarb_cell #(.IDX(i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_use   (5'(i) < n_used),
      .alive    (c_alive),
      .present  (c_present),
      .kind     (c_kind),
      .want_kind(want_kind),
      .scan_in  (scan_chain[i]),
      .scan_out (scan_chain[i+1]),
      .upd      (upd),
      .stat     (stats[i])
    );
  end

  ladarb_ram #(.WIDTH(LAT_W), .DEPTH(2 ** RAM_AW)) u_window (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_addr),
    .wdata(lat_q),
    .re   (ram_re),
    .raddr(ram_addr),
    .rdata(ram_rdata)
  );

  ladarb_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(sum_new),
    .divisor (fill_new),
    .done    (div_done),
    .quotient(div_q)
  );

  assign ram_addr  = {slot_q[SLOT_W-1:0], work.head[WIN_AW-1:0]};
  assign ram_re    = state == S_READ;
  assign ram_we    = state == S_SUM;
  assign div_start = state == S_SUM;
  assign win_full  = work.fill >= FILL_W'(WINDOW_DEPTH);
  assign sum_new   = work.sum - (win_full ? SUM_W'(ram_rdata) : '0) + SUM_W'(lat_q);
  assign fill_new  = win_full ? work.fill : work.fill + FILL_W'(1);
  assign head_inc  = {1'b0, work.head} + (HEAD_W+1)'(1);

  always_comb begin
    ok_stat          = in_stat;
    ok_stat.total    = in_stat.total + CNT_W'(1);
    fail_stat        = ok_stat;
    fail_stat.failed = in_stat.failed + CNT_W'(1);
    sum_stat         = work;
    sum_stat.sum     = sum_new;
    sum_stat.fill    = fill_new;
    sum_stat.head    = (head_inc == (HEAD_W+1)'(WINDOW_DEPTH)) ? '0 : head_inc[HEAD_W-1:0];
    done_stat        = work;
    done_stat.avg    = div_q;
  end

  always_comb begin
    if (strategy inside {STRAT_GPU_BACKFILL, STRAT_NPU_BACKFILL, STRAT_GPU_ONLY,
                         STRAT_NPU_ONLY}) begin
      pick = scan_chain[NUM_SLOTS].kind_found ? scan_chain[NUM_SLOTS].kind_idx : '0;
    end else if (scan_chain[NUM_SLOTS].fast_found) begin
      pick = scan_chain[NUM_SLOTS].fast_idx;
    end else begin
      pick = scan_chain[NUM_SLOTS].ap_found ? scan_chain[NUM_SLOTS].ap_idx : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      scan_cnt     <= '0;
      phase        <= '0;
      want_kind    <= KIND_OTHER;
      strategy     <= STRAT_FASTEST;
      slot_count   <= '0;
      slot_kinds   <= '0;
      present_mask <= '0;
      alive_mask   <= '1;
      out_valid    <= 1'b0;
      upd_we       <= 1'b0;
    end else begin
      upd_we <= (state == S_IDLE && in_valid && op && in_slot_ok && !success) ||
                (state == S_DIV && div_done);
      if (state == S_DIV) begin
        upd_slot <= slot_q;
        upd_stat <= done_stat;
      end else begin
        upd_slot <= in_slot;
        upd_stat <= fail_stat;
      end
      if (cfg_valid) begin
        case (cfg_index)
          REG_STRATEGY:   strategy     <= cfg_data[2:0];
          REG_SLOT_COUNT: slot_count   <= cfg_data[3:0];
          REG_SLOT_KINDS: slot_kinds   <= cfg_data;
          REG_PRESENT:    present_mask <= cfg_data[7:0];
          REG_ALIVE:      alive_mask   <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (state == S_OUT && (!out_valid || out_ready)) begin
        out_valid    <= 1'b1;
        dispatched   <= res_dispatched;
        chosen_slot  <= res_slot;
        average_us   <= res_avg;
        total_count  <= res_total;
        failed_count <= res_failed;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            slot_q <= in_slot;
            lat_q  <= latency_us;
            if (!op) begin
              res_slot   <= '0;
              res_avg    <= '0;
              res_total  <= '0;
              res_failed <= '0;
              if (n_used >= 5'd2) begin
                res_dispatched <= 1'b0;
                state          <= S_SCAN;
                scan_cnt       <= '0;
                case (strategy)
                  STRAT_GPU_ONLY: want_kind <= KIND_GPU;
                  STRAT_NPU_ONLY: want_kind <= KIND_NPU;
                  STRAT_GPU_BACKFILL: want_kind <= (phase < PREF_PICKS) ? KIND_GPU : KIND_NPU;
                  STRAT_NPU_BACKFILL: want_kind <= (phase < PREF_PICKS) ? KIND_NPU : KIND_GPU;
                  default: want_kind <= KIND_OTHER;
                endcase
                if (strategy inside {STRAT_GPU_BACKFILL, STRAT_NPU_BACKFILL}) begin
                  phase <= (phase == PHASE_LAST) ? '0 : phase + 3'd1;
                end
              end else begin
                res_dispatched <= (n_used == 5'd1) ? present_mask[0] : 1'b0;
                state          <= S_OUT;
              end
            end else begin
              res_slot       <= slot;
              res_dispatched <= 1'b0;
              if (in_slot_ok && success) begin
                work  <= ok_stat;
                state <= S_READ;
              end else begin
                res_avg    <= (in_slot_ok && in_stat.fill != '0) ? in_stat.avg : '0;
                res_total  <= in_slot_ok ? fail_stat.total : '0;
                res_failed <= in_slot_ok ? fail_stat.failed : '0;
                state      <= S_OUT;
              end
            end
          end
        end
        S_SCAN: begin
          scan_cnt <= scan_cnt + SCAN_W'(1);
          if (scan_cnt == SCAN_W'(NUM_SLOTS)) begin
            res_slot       <= pick[2:0];
            res_dispatched <= (pick < SLOT_IDX_W'(8)) ? present_mask[pick[2:0]] : 1'b0;
            state          <= S_OUT;
          end
        end
        S_READ: begin
          state <= S_SUM;
        end
        S_SUM: begin
          work  <= sum_stat;
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            res_avg    <= div_q;
            res_total  <= work.total;
            res_failed <= work.failed;
            state      <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `LADARB_ASSERT_IMP(a_div_done_in_div, div_done, state == S_DIV)
  `LADARB_ASSERT_IMP(a_phase_range, 1'b1, phase <= PHASE_LAST)
  `LADARB_ASSERT_IMP(a_fill_bound, upd.we, upd.stat.fill <= FILL_W'(WINDOW_DEPTH))
  `LADARB_ASSERT_NXT(a_accept_busy, in_valid && in_ready, state != S_IDLE)

endmodule
